>>> design/mchd_pkg.sv
// Shared types and constants for the multi-click and hold detector.
// No dependencies; used by every other file of the block.
`default_nettype none

package mchd_pkg;

  // Default width of the internal timestamp arithmetic.
  localparam int unsigned TimeBitsDefault = 32;

  // Field widths of the streams and the configuration port.
  localparam int unsigned NowWidth   = 32;
  localparam int unsigned CountWidth = 8;
  localparam int unsigned MsWidth    = 16;
  localparam int unsigned CfgIdxWidth = 4;

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_ENABLE = 4'd0,
    CFG_NOISE  = 4'd1,
    CFG_HOLD   = 4'd2,
    CFG_GAP    = 4'd3
  } cfg_idx_e;

  // Register values after reset.
  localparam logic               EnableReset = 1'b1;
  localparam logic [MsWidth-1:0] NoiseReset  = 16'd30;
  localparam logic [MsWidth-1:0] HoldReset   = 16'd800;
  localparam logic [MsWidth-1:0] GapReset    = 16'd400;

  // Kinds of event reported on the result stream.
  typedef enum logic [1:0] {
    EV_CLICK      = 2'd0,
    EV_HOLD_START = 2'd1,
    EV_HOLD_END   = 2'd2
  } event_e;

  // Configuration as seen by the detector core.
  typedef struct packed {
    logic               enable;
    logic [MsWidth-1:0] noise_ms;
    logic [MsWidth-1:0] hold_ms;
    logic [MsWidth-1:0] gap_ms;
  } cfg_t;

  // One event produced by the core for a poll.
  typedef struct packed {
    logic                  valid;
    event_e                kind;
    logic [CountWidth-1:0] count;
  } event_t;

endpackage

`default_nettype wire

>>> design/mchd_cfg.sv
// Configuration register file of the multi-click and hold detector.
// Depends on mchd_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module mchd_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [mchd_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [mchd_pkg::MsWidth-1:0]      cfg_wdata_i,
  output      mchd_pkg::cfg_t                    cfg_o
);

  mchd_pkg::cfg_t cfg_q, cfg_d;

  // Writes are always taken; an unknown index leaves everything unchanged.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mchd_pkg::CFG_ENABLE: cfg_d.enable   = cfg_wdata_i[0];
        mchd_pkg::CFG_NOISE:  cfg_d.noise_ms = cfg_wdata_i;
        mchd_pkg::CFG_HOLD:   cfg_d.hold_ms  = cfg_wdata_i;
        mchd_pkg::CFG_GAP:    cfg_d.gap_ms   = cfg_wdata_i;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable   <= mchd_pkg::EnableReset;
      cfg_q.noise_ms <= mchd_pkg::NoiseReset;
      cfg_q.hold_ms  <= mchd_pkg::HoldReset;
      cfg_q.gap_ms   <= mchd_pkg::GapReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> design/mchd_step.sv
// Detector core: phase machine, click counter, stored level and change time.
// Depends on mchd_pkg for cfg_t, event_t and the event kinds.
`default_nettype none

module mchd_step #(
  parameter int unsigned TIME_BITS = mchd_pkg::TimeBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          fire_i,
  input  wire logic                          level_i,
  input  wire logic [mchd_pkg::NowWidth-1:0] now_ms_i,
  input  wire mchd_pkg::cfg_t                cfg_i,
  output      mchd_pkg::event_t              event_o
);

  typedef enum logic [1:0] {
    PH_IDLE         = 2'd0,
    PH_WAIT_RELEASE = 2'd1,
    PH_WAIT_PRESS   = 2'd2,
    PH_HOLD         = 2'd3
  } phase_e;

  localparam logic [mchd_pkg::CountWidth-1:0] CountMax = '1;

  phase_e                            phase_q, phase_d;
  logic [mchd_pkg::CountWidth-1:0]   clicks_q, clicks_d;
  logic                              prev_level_q, prev_level_d;
  logic [TIME_BITS-1:0]              last_ms_q, last_ms_d;

  logic [63:0]          now_wide, noise_wide, hold_wide, gap_wide;
  logic [TIME_BITS-1:0] now_t, noise_t, hold_t, gap_t, elapsed;
  logic                 changed, press_edge, release_edge;

  // Timestamps and thresholds are brought to the internal time width.
  assign now_wide   = {32'd0, now_ms_i};
  assign noise_wide = {48'd0, cfg_i.noise_ms};
  assign hold_wide  = {48'd0, cfg_i.hold_ms};
  assign gap_wide   = {48'd0, cfg_i.gap_ms};
  assign now_t      = now_wide[TIME_BITS-1:0];
  assign noise_t    = noise_wide[TIME_BITS-1:0];
  assign hold_t     = hold_wide[TIME_BITS-1:0];
  assign gap_t      = gap_wide[TIME_BITS-1:0];

  assign elapsed      = now_t - last_ms_q;
  assign changed      = level_i != prev_level_q;
  assign press_edge   = !level_i && prev_level_q;
  assign release_edge = level_i && !prev_level_q;

  always_comb begin
    phase_d       = phase_q;
    clicks_d      = clicks_q;
    prev_level_d  = prev_level_q;
    last_ms_d     = last_ms_q;
    event_o.valid = 1'b0;
    event_o.kind  = mchd_pkg::EV_CLICK;
    event_o.count = clicks_q;

    if (fire_i && cfg_i.enable) begin
      if (changed && (elapsed < noise_t)) begin
        // Noise: only the stored level and time move.
        prev_level_d = level_i;
        last_ms_d    = now_t;
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
            if (press_edge) phase_d = PH_WAIT_RELEASE;
          end
          PH_WAIT_RELEASE: begin
            if (elapsed > hold_t) begin
              phase_d       = PH_HOLD;
              event_o.valid = 1'b1;
              event_o.kind  = mchd_pkg::EV_HOLD_START;
            end else if (release_edge) begin
              phase_d = PH_WAIT_PRESS;
              if (clicks_q != CountMax) clicks_d = clicks_q + 1'b1;
            end
          end
          PH_WAIT_PRESS: begin
            if (elapsed > gap_t) begin
              phase_d       = PH_IDLE;
              clicks_d      = '0;
              event_o.valid = 1'b1;
              event_o.kind  = mchd_pkg::EV_CLICK;
            end else if (press_edge) begin
              phase_d = PH_WAIT_RELEASE;
            end
          end
          PH_HOLD: begin
            if (release_edge) begin
              phase_d       = PH_IDLE;
              clicks_d      = '0;
              event_o.valid = 1'b1;
              event_o.kind  = mchd_pkg::EV_HOLD_END;
              event_o.count = '0;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
        if (changed) begin
          prev_level_d = level_i;
          last_ms_d    = now_t;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      clicks_q     <= '0;
      prev_level_q <= 1'b1;
      last_ms_q    <= '0;
    end else begin
      phase_q      <= phase_d;
      clicks_q     <= clicks_d;
      prev_level_q <= prev_level_d;
      last_ms_q    <= last_ms_d;
    end
  end

endmodule

`default_nettype wire

>>> design/multi_click_hold_detector.sv
// Top level of the multi-click and hold detector: input register, core, result register.
// Depends on mchd_pkg, mchd_cfg and mchd_step.
//
// Usage. Each request on the slave stream is one poll of an active-low button:
// the sampled line level and a millisecond timestamp. The detector reports at
// most one event per poll on the master stream: a finished click sequence with
// its count, the start of a hold with the clicks before it, or the end of a hold.
// Polls that produce no event are consumed silently.
// A poll accepted on the slave stream is first held in the input register, then
// evaluated by the core; its event is held in the result register and presented
// from there on the master stream.
// Throughput: one poll per cycle while the event receiver does not stall; the phase
// machine has no busy state, so consecutive polls flow without gaps.
// When the receiver stalls, the result register holds its event and the input
// register holds one more poll; s_axis_tready falls only when both are full, and
// rises again in the same cycle that m_axis_tready takes the waiting event.
// Configuration writes are always accepted on the cfg channel and should be made
// only while no poll is in flight.
// Reset (asynchronous, active low) empties both registers, returns the machine to
// idle with no clicks, a released line and a change time of zero, and loads the
// register defaults: enabled, noise 30 ms, hold 800 ms, gap 400 ms.
`default_nettype none

module multi_click_hold_detector #(
  parameter int unsigned TIME_BITS = mchd_pkg::TimeBitsDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Poll stream.
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  input  wire logic [39:0]                       s_axis_tdata,  // [0] level, [32:1] now_ms
  // Event stream.
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output      logic [7:0]                        m_axis_tdata,  // [7:0] click_count
  output      logic [1:0]                        m_axis_tuser,  // [1:0] event_kind
  // Configuration write channel.
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [mchd_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [mchd_pkg::MsWidth-1:0]      cfg_wdata_i
);

  mchd_pkg::cfg_t   cfg;
  mchd_pkg::event_t step_event;

  logic                          in_valid_q;
  logic                          in_level_q;
  logic [mchd_pkg::NowWidth-1:0] in_now_q;
  logic                          out_valid_q;
  mchd_pkg::event_e              out_kind_q;
  logic [mchd_pkg::CountWidth-1:0] out_count_q;
  logic                          advance;

  // The held poll moves on whenever the result register is free or being emptied.
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  mchd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mchd_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (in_valid_q && advance),
    .level_i  (in_level_q),
    .now_ms_i (in_now_q),
    .cfg_i    (cfg),
    .event_o  (step_event)
  );

  // Input register: control is reset, payload only loads on a request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_level_q <= s_axis_tdata[0];
      in_now_q   <= s_axis_tdata[32:1];
    end
  end

  // Result register: filled only by polls that raise an event.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && step_event.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && step_event.valid) begin
      out_kind_q  <= step_event.kind;
      out_count_q <= step_event.count;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_count_q;
  assign m_axis_tuser  = out_kind_q;

endmodule

`default_nettype wire

>>> verif/multi_click_hold_detector_tb.sv
// Self-checking testbench for multi_click_hold_detector: button polls are streamed in, and
// every reported click and hold event is checked against a cycle-free predictor of the block.
// Depends on mchd_pkg and the multi_click_hold_detector RTL only.
`timescale 1ns / 1ps

module multi_click_hold_detector_tb;
  import mchd_pkg::*;

  localparam int unsigned ClkHalf     = 5;
  localparam int unsigned ResetCycles = 4;
  // Margin for the input and result registers, plus a poll held behind a stalled event.
  localparam int unsigned DrainPause  = 8;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned PrintLimit  = 50;

  // Indexes past the register list; writes there must change nothing.
  localparam logic [CfgIdxWidth-1:0] CfgIdxFirstSpare = CfgIdxWidth'(CFG_GAP + 1);
  localparam int unsigned CfgSpareCount = 2 ** CfgIdxWidth - CfgIdxFirstSpare;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT_RELEASE,
    PH_WAIT_PRESS,
    PH_HOLD
  } det_phase_e;

  typedef struct packed {
    event_e                kind;
    logic [CountWidth-1:0] count;
  } event_rec_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [39:0]            s_axis_tdata  = '0;  // [0] level, [32:1] now_ms
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [7:0]             m_axis_tdata;        // [7:0] click_count
  logic [1:0]             m_axis_tuser;        // [1:0] event_kind
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i   = '0;
  logic [MsWidth-1:0]     cfg_wdata_i   = '0;

  // Mirror of the register file and of the detector state.
  logic                  reg_enable;
  logic [MsWidth-1:0]    reg_noise;
  logic [MsWidth-1:0]    reg_hold;
  logic [MsWidth-1:0]    reg_gap;
  det_phase_e            det_phase;
  logic [CountWidth-1:0] det_clicks;
  logic                  det_level;
  logic [NowWidth-1:0]   det_last_ms;

  event_rec_t  pending_events[$];
  int unsigned err_count    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned polls_sent   = 0;
  int unsigned rx_stall_left = 0;
  logic [31:0] stamp_ms     = '0;
  bit          tx_gaps      = 1'b1;
  bit          rx_gaps      = 1'b1;

  multi_click_hold_detector u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    if (err_count < PrintLimit) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    err_count++;
  endtask

  // Works out the event, if any, that one accepted poll causes, and moves the mirrored
  // state on. Elapsed time is taken modulo 2^32, so timestamp wrap needs no special case.
  function automatic void detect_poll(input logic lvl, input logic [NowWidth-1:0] now);
    logic [NowWidth-1:0] elapsed;
    logic                changed;
    logic                press_edge;
    logic                release_edge;
    elapsed      = now - det_last_ms;
    changed      = lvl != det_level;
    press_edge   = !lvl && det_level;
    release_edge = lvl && !det_level;
    if (!reg_enable) return;
    // A change inside the noise window only refreshes the stored level and time.
    if (changed && elapsed < reg_noise) begin
      det_level   = lvl;
      det_last_ms = now;
      return;
    end
    case (det_phase)
      PH_IDLE: begin
        if (press_edge) det_phase = PH_WAIT_RELEASE;
      end
      PH_WAIT_RELEASE: begin
        // The timeout is checked before the level change of the same poll.
        if (elapsed > reg_hold) begin
          det_phase = PH_HOLD;
          pending_events.push_back('{kind: EV_HOLD_START, count: det_clicks});
        end else if (release_edge) begin
          det_phase = PH_WAIT_PRESS;
          if (det_clicks != '1) det_clicks++;
        end
      end
      PH_WAIT_PRESS: begin
        if (elapsed > reg_gap) begin
          pending_events.push_back('{kind: EV_CLICK, count: det_clicks});
          det_clicks = '0;
          det_phase  = PH_IDLE;
        end else if (press_edge) begin
          det_phase = PH_WAIT_RELEASE;
        end
      end
      default: begin
        if (release_edge) begin
          pending_events.push_back('{kind: EV_HOLD_END, count: '0});
          det_clicks = '0;
          det_phase  = PH_IDLE;
        end
      end
    endcase
    if (changed) begin
      det_level   = lvl;
      det_last_ms = now;
    end
  endfunction

  // Observes all three channels at each edge: events are checked first, then register
  // writes and polls update the mirror, so a poll's expectation is queued in time.
  always @(posedge clk_i) begin
    event_rec_t want;
    if (!rst_ni) begin
      reg_enable  = EnableReset;
      reg_noise   = NoiseReset;
      reg_hold    = HoldReset;
      reg_gap     = GapReset;
      det_phase   = PH_IDLE;
      det_clicks  = '0;
      det_level   = 1'b1;
      det_last_ms = '0;
      pending_events.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("event with none expected: kind %0d count %0d",
                                    m_axis_tuser, m_axis_tdata));
        end else begin
          want = pending_events.pop_front();
          if (m_axis_tuser !== want.kind) begin
            report_mismatch($sformatf("event kind %0d, expected %0d", m_axis_tuser,
                                      want.kind));
          end
          if (m_axis_tdata !== want.count) begin
            report_mismatch($sformatf("click count %0d, expected %0d (kind %0d)",
                                      m_axis_tdata, want.count, want.kind));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ENABLE: reg_enable = cfg_wdata_i[0];
          CFG_NOISE:  reg_noise  = cfg_wdata_i;
          CFG_HOLD:   reg_hold   = cfg_wdata_i;
          CFG_GAP:    reg_gap    = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        detect_poll(s_axis_tdata[0], s_axis_tdata[32:1]);
      end
    end
  end

  // Event receiver: stalls come in random bursts while enabled.
  always @(posedge clk_i) begin
    if (rx_stall_left != 0) begin
      rx_stall_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
      rx_stall_left = $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Ends the run once nothing at all has been accepted for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("multi_click_hold_detector_tb: FAIL");
      $finish;
    end
  end

  // Sends one poll request and returns at the edge that accepts it, leaving tvalid high.
  task automatic send_poll(input logic lvl, input logic [31:0] now);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, now, lvl};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic step(input logic lvl, input logic [31:0] delta);
    stamp_ms += delta;
    send_poll(lvl, stamp_ms);
    if (reg_enable) polls_sent++;
  endtask

  // Stops the poll stream and waits until every expected event has been taken.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_events.size() != 0);
    repeat (DrainPause) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [MsWidth-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Writes all four registers, the enable bit with random upper bits, and one spare index.
  task automatic configure(input logic en, input logic [MsWidth-1:0] noise_ms,
                           input logic [MsWidth-1:0] hold_ms, input logic [MsWidth-1:0] gap_ms);
    write_reg(CFG_ENABLE, {15'($urandom), en});
    write_reg(CFG_NOISE, noise_ms);
    write_reg(CFG_HOLD, hold_ms);
    write_reg(CFG_GAP, gap_ms);
    write_reg(CfgIdxFirstSpare + 4'($urandom_range(0, CfgSpareCount - 1)), 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Random duration in [lo, hi], landing on either end a quarter of the time.
  function automatic logic [31:0] pick_ms(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (hi <= lo || r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(hi, lo);
  endfunction

  function automatic logic [31:0] near(input int unsigned thr);
    return pick_ms(thr == 0 ? 0 : thr - 1, thr + 1);
  endfunction

  task automatic click_run(input int unsigned clicks);
    for (int unsigned i = 0; i < clicks; i++) begin
      step(1'b0, pick_ms(32'(reg_noise), 32'(reg_gap)));
      step(1'b1, pick_ms(32'(reg_noise), 32'(reg_hold)));
    end
    step(1'b1, pick_ms(reg_gap + 1, reg_gap + 600));
  endtask

  task automatic hold_run(input int unsigned prior_clicks);
    for (int unsigned i = 0; i < prior_clicks; i++) begin
      step(1'b0, pick_ms(32'(reg_noise), 32'(reg_gap)));
      step(1'b1, pick_ms(32'(reg_noise), 32'(reg_hold)));
    end
    step(1'b0, pick_ms(32'(reg_noise), 32'(reg_gap)));
    if ($urandom_range(0, 3) == 0) begin
      // Release on the very poll that times out: the hold still starts.
      step(1'b1, pick_ms(reg_hold + 1, reg_hold + 300));
      step(1'b0, pick_ms(32'(reg_noise), reg_noise + 200));
      step(1'b1, pick_ms(32'(reg_noise), reg_noise + 200));
    end else begin
      step(1'b0, pick_ms(reg_hold + 1, reg_hold + 300));
      repeat ($urandom_range(0, 2)) step(1'b0, pick_ms(0, 100));
      step(1'b1, pick_ms(32'(reg_noise), 300));
    end
  endtask

  task automatic random_poll();
    logic [31:0] delta;
    case ($urandom_range(0, 5))
      0:       delta = pick_ms(0, 3);
      1:       delta = near(32'(reg_noise));
      2:       delta = near(32'(reg_hold));
      3:       delta = near(32'(reg_gap));
      4:       delta = pick_ms(0, 2000);
      default: delta = $urandom;
    endcase
    step(1'(($urandom)), delta);
  endtask

  // Bounce on the line: level flips faster than the noise window, then settles released.
  task automatic bounce_run();
    logic lvl;
    lvl = 1'b0;
    if (reg_noise == 0) begin
      random_poll();
    end else begin
      repeat ($urandom_range(1, 4)) begin
        step(lvl, pick_ms(0, reg_noise - 1));
        lvl = ~lvl;
      end
      step(1'b1, pick_ms(32'(reg_noise), reg_noise + 100));
    end
  endtask

  task automatic run_phase(input logic [MsWidth-1:0] noise_ms, input logic [MsWidth-1:0] hold_ms,
                           input logic [MsWidth-1:0] gap_ms, input int unsigned count,
                           input bit tx_idle, input bit rx_idle);
    int unsigned target;
    settle();
    configure(1'b1, noise_ms, hold_ms, gap_ms);
    tx_gaps = tx_idle;
    rx_gaps = rx_idle;
    target  = polls_sent + count;
    while (polls_sent < target) begin
      case ($urandom_range(0, 29))
        0:                  settle();
        1, 2, 3, 4, 5, 6:   click_run($urandom_range(1, 3));
        7, 8, 9, 10:        click_run($urandom_range(1, 6));
        11, 12, 13, 14, 15: hold_run($urandom_range(0, 2));
        16, 17, 18, 19:     bounce_run();
        default:            repeat ($urandom_range(1, 4)) random_poll();
      endcase
    end
  endtask

  // Single and double clicks, exact gap and hold boundaries, bounce, a hold, a release
  // on the timing-out poll, and a click across the timestamp wrap, under reset settings.
  task automatic test_directed();
    send_poll(1'b1, 32'd10);
    send_poll(1'b0, 32'd100);
    send_poll(1'b1, 32'd200);
    send_poll(1'b1, 32'd700);
    send_poll(1'b0, 32'd1000);
    send_poll(1'b1, 32'd1100);
    send_poll(1'b0, 32'd1200);
    send_poll(1'b1, 32'd1300);
    send_poll(1'b1, 32'd1700);
    send_poll(1'b1, 32'd1701);
    send_poll(1'b0, 32'd2000);
    send_poll(1'b1, 32'd2010);
    send_poll(1'b0, 32'd2020);
    send_poll(1'b0, 32'd2820);
    send_poll(1'b0, 32'd2821);
    send_poll(1'b1, 32'd2900);
    send_poll(1'b0, 32'd3000);
    send_poll(1'b1, 32'd3801);
    send_poll(1'b0, 32'd3850);
    send_poll(1'b1, 32'd3900);
    send_poll(1'b0, 32'hFFFF_FFF0);
    send_poll(1'b1, 32'h0000_0050);
    send_poll(1'b1, 32'h0000_01E1);
    stamp_ms = 32'h0000_01E1;
  endtask

  // A press is left pending while the detector is switched off; ignored polls must not
  // disturb it, and the click completes once it is switched back on.
  task automatic test_disable();
    step(1'b0, 32'd100);
    settle();
    configure(1'b0, NoiseReset, HoldReset, GapReset);
    repeat (12) send_poll(1'(($urandom)), $urandom);
    settle();
    configure(1'b1, NoiseReset, HoldReset, GapReset);
    step(1'b1, 32'd100);
    step(1'b1, 32'd401);
  endtask

  // More releases than the counter holds, with the noise filter off.
  task automatic test_saturation();
    settle();
    configure(1'b1, '0, '1, '1);
    repeat (257) begin
      step(1'b0, pick_ms(1, 60));
      step(1'b1, pick_ms(1, 60));
    end
    step(1'b1, 32'h0001_0000);
  endtask

  task automatic test_random_phases();
    run_phase(16'($urandom_range(0, 60)), 16'($urandom_range(20, 1500)),
              16'($urandom_range(10, 900)), 220, 1'b1, 1'b1);
    run_phase('0, '0, '0, 120, 1'b1, 1'b1);
    run_phase('1, '1, '1, 120, 1'b1, 1'b0);
    run_phase(16'($urandom_range(0, 60)), 16'($urandom_range(20, 1500)),
              16'($urandom_range(10, 900)), 220, 1'b0, 1'b1);
    run_phase(NoiseReset, HoldReset, GapReset, 200, 1'b1, 1'b1);
    // Last stretch runs at full rate on both sides.
    run_phase(16'($urandom_range(0, 60)), 16'($urandom_range(20, 1500)),
              16'($urandom_range(10, 900)), 250, 1'b0, 1'b0);
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_disable();
    test_saturation();
    test_random_phases();
    settle();
    if (err_count == 0 && pending_events.size() == 0) begin
      $display("multi_click_hold_detector_tb: PASS");
    end else begin
      $display("multi_click_hold_detector_tb: FAIL");
    end
    $finish;
  end

endmodule
